// File: rtl/id3fte_pkg.sv
// shared types and constants for the id3v2 frame text extractor
// no dependencies; imported by every module of the block
package id3fte_pkg;

  localparam int unsigned HdrLen = 10;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] BYTE_SKIP2 = 8'd1;
  localparam logic [7:0] BYTE_SKIP1 = 8'd255;

  typedef enum logic [3:0] {
    PH_TAG_HDR   = 4'b0001,
    PH_FRAME_HDR = 4'b0010,
    PH_PAYLOAD   = 4'b0100,
    PH_DONE      = 4'b1000
  } phase_e;

  // results of one input word: a first result and an optional trailing end of tag
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [31:0] frame_tag;
    logic        two;
  } rec_t;

endpackage

// File: rtl/id3v2_frame_text_extractor.sv
// top level of the id3v2 frame text extractor
// instantiates id3fte_parse, id3fte_fifo and id3fte_emit; uses id3fte_pkg
//
// usage:
//   s_axis carries the file one byte per word; tuser marks the file's first
//   byte and restarts parsing there. m_axis carries results: frame start
//   with its id, text characters and end of tag; tlast marks the final
//   result caused by one input byte.
//   the parser takes one byte per cycle whenever the result queue has room,
//   bytes that cause no result never touch the queue.
//   a result enters the queue as its byte is taken, then the output register.
//   throughput: one byte per cycle in while the queue has room, one result
//   per cycle out while the receiver is ready; a byte with two results puts
//   its first result and then the end of tag through the output register.
//   when the receiver stalls, the output register holds its word and the
//   queue (FifoDepth records) fills; s_axis_tready drops only when it is full.
//   reset clears the parser to the tag header and empties queue and output.
//   after end of tag, bytes are taken and dropped until tuser is set.
module id3v2_frame_text_extractor #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [1:0] kind, [9:2] value, [41:10] frame_tag, rest zero
  output logic        m_axis_tlast
);
  import id3fte_pkg::*;

  rec_t        push_rec;
  rec_t        pop_rec;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic [31:0] frame_tag;

  id3fte_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .data_byte_i (s_axis_tdata),
    .first_i     (s_axis_tuser),
    .full_i      (full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  id3fte_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .pop_i   (pop),
    .rdata_o (pop_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  id3fte_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .kind_o      (kind),
    .value_o     (value),
    .frame_tag_o (frame_tag),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, frame_tag, value, kind};

endmodule

// File: rtl/id3fte_parse.sv
// front part: takes one file byte per word, tracks tag and frame structure
// and pushes a result record for every byte that causes results; uses id3fte_pkg
module id3fte_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_i,
  input  logic              full_i,
  output logic              in_ready_o,
  output logic              push_o,
  output id3fte_pkg::rec_t  rec_o
);
  import id3fte_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  hidx_q, hidx_d;
  logic [31:0] tag_left_q, tag_left_d;
  logic [31:0] frame_left_q, frame_left_d;
  logic [31:0] size_q, size_d;
  logic [31:0] id_q, id_d;
  logic [1:0]  skip_q, skip_d;

  phase_e      ph;
  logic [3:0]  hi;
  logic [31:0] tl, fl, sz, idv;
  logic [1:0]  sk;
  logic [31:0] addend;
  logic [3:0]  hnext;
  logic        res_any;
  logic        accept;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;

  always_comb begin
    ph  = phase_q;
    hi  = hidx_q;
    tl  = tag_left_q;
    fl  = frame_left_q;
    sz  = size_q;
    idv = id_q;
    sk  = skip_q;
    if (first_i) begin
      ph  = PH_TAG_HDR;
      hi  = '0;
      tl  = '0;
      fl  = '0;
      sz  = '0;
      idv = '0;
      sk  = '0;
    end

    phase_d      = ph;
    hidx_d       = hi;
    tag_left_d   = tl;
    frame_left_d = fl;
    size_d       = sz;
    id_d         = idv;
    skip_d       = sk;
    res_any      = 1'b0;
    rec_o        = '0;
    addend       = '0;
    hnext        = hi + 4'd1;

    case (ph)
      PH_TAG_HDR: begin
        case (hi)
          4'd6:    addend = {3'b0, data_byte_i, 21'b0};
          4'd7:    addend = {10'b0, data_byte_i, 14'b0};
          4'd8:    addend = {17'b0, data_byte_i, 7'b0};
          4'd9:    addend = {24'b0, data_byte_i};
          default: addend = '0;
        endcase
        size_d = sz + addend;
        hidx_d = hnext;
        if (hnext >= 4'(HdrLen)) begin
          tag_left_d = size_d;
          size_d     = '0;
          hidx_d     = '0;
          if (tag_left_d == '0) begin
            res_any    = 1'b1;
            rec_o.kind = KIND_END;
            phase_d    = PH_DONE;
          end else begin
            phase_d = PH_FRAME_HDR;
          end
        end
      end
      PH_FRAME_HDR: begin
        tag_left_d = tl - 32'd1;
        if (hi < 4'd4) begin
          id_d = {idv[23:0], data_byte_i};
        end else if (hi < 4'd8) begin
          size_d = {sz[23:0], data_byte_i};
        end
        hidx_d = hnext;
        if (hnext == 4'd8 && size_d == '0) begin
          res_any    = 1'b1;
          rec_o.kind = KIND_END;
          phase_d    = PH_DONE;
        end else begin
          if (hnext >= 4'(HdrLen)) begin
            frame_left_d    = size_d;
            hidx_d          = '0;
            skip_d          = '0;
            res_any         = 1'b1;
            rec_o.kind      = KIND_FRAME;
            rec_o.frame_tag = id_d;
            phase_d         = PH_PAYLOAD;
          end
          if (tag_left_d == '0) begin
            if (res_any) begin
              rec_o.two = 1'b1;
            end else begin
              res_any    = 1'b1;
              rec_o.kind = KIND_END;
            end
            phase_d = PH_DONE;
          end
        end
      end
      PH_PAYLOAD: begin
        tag_left_d = tl - 32'd1;
        if (sk != 2'd0) begin
          skip_d = sk - 2'd1;
        end else if (data_byte_i == BYTE_SKIP2) begin
          skip_d = 2'd2;
        end else if (data_byte_i == BYTE_SKIP1) begin
          skip_d = 2'd1;
        end else if (data_byte_i != 8'd0) begin
          res_any     = 1'b1;
          rec_o.kind  = KIND_TEXT;
          rec_o.value = data_byte_i;
        end
        frame_left_d = fl - 32'd1;
        if (frame_left_d == '0) begin
          phase_d = PH_FRAME_HDR;
          hidx_d  = '0;
          skip_d  = '0;
        end
        if (tag_left_d == '0) begin
          if (res_any) begin
            rec_o.two = 1'b1;
          end else begin
            res_any    = 1'b1;
            rec_o.kind = KIND_END;
          end
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_TAG_HDR;
      end
    endcase
  end

  assign push_o = accept & res_any;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TAG_HDR;
      hidx_q       <= '0;
      tag_left_q   <= '0;
      frame_left_q <= '0;
      size_q       <= '0;
      id_q         <= '0;
      skip_q       <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      hidx_q       <= hidx_d;
      tag_left_q   <= tag_left_d;
      frame_left_q <= frame_left_d;
      size_q       <= size_d;
      id_q         <= id_d;
      skip_q       <= skip_d;
    end
  end

endmodule

// File: rtl/id3fte_fifo.sv
// short queue of result records between the parser and the output stage
// uses id3fte_pkg for the record type
module id3fte_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  id3fte_pkg::rec_t wdata_i,
  input  logic             pop_i,
  output id3fte_pkg::rec_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import id3fte_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/id3fte_emit.sv
// back part: pops result records and drives the output register,
// one result per word, splitting a two-result record; uses id3fte_pkg
module id3fte_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  id3fte_pkg::rec_t rec_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       kind_o,
  output logic [7:0]       value_o,
  output logic [31:0]      frame_tag_o,
  output logic             last_o
);
  import id3fte_pkg::*;

  logic        valid_q, valid_d;
  logic        pend_q, pend_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  value_q, value_d;
  logic [31:0] tag_q, tag_d;
  logic        last_q, last_d;
  logic        load_ok;

  assign load_ok = ~valid_q | out_ready_i;

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    kind_d  = kind_q;
    value_d = value_q;
    tag_d   = tag_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load_ok) begin
      if (pend_q) begin
        valid_d = 1'b1;
        pend_d  = 1'b0;
        kind_d  = KIND_END;
        value_d = '0;
        tag_d   = '0;
        last_d  = 1'b1;
      end else if (!empty_i) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        pend_d  = rec_i.two;
        kind_d  = rec_i.kind;
        value_d = rec_i.value;
        tag_d   = rec_i.frame_tag;
        last_d  = ~rec_i.two;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    tag_q   <= tag_d;
    last_q  <= last_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign frame_tag_o = tag_q;
  assign last_o      = last_q;

endmodule
